[hdl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and functions of the crc burst framer
// queue entry layout, crc-16 byte update and sizing constants
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  LIMIT_RESET = 8'd255;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	typedef struct packed {
		logic [15:0] crc;
		logic [7:0]  data;
		logic        start;
		logic        fin;
	} entry_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic [15:0] d;
		logic        top;
		c = crc;
		d = {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			top = c[15] ^ d[15];
			c = {c[14:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
			d = {d[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[hdl/cbf_front.sv]
// ----------------------------------------------------------------------------
// cbf_front: input side of the crc burst framer
// accepts image words, tracks burst position and running crc, fills the queue
// ----------------------------------------------------------------------------
module cbf_front import cbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);

	logic [7:0]  chunk_limit_q;
	logic [7:0]  burst_count_q;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic [8:0]  lim;
	logic [8:0]  cnt_next;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	assign crc_next = crc16_byte(crc_q, s_axis_tdata);
	assign lim      = (chunk_limit_q == 8'd0) ? 9'd1 : {1'b0, chunk_limit_q};
	assign cnt_next = {1'b0, burst_count_q} + 9'd1;

	always_comb begin
		push_entry.crc   = crc_next;
		push_entry.data  = s_axis_tdata;
		push_entry.start = (burst_count_q == 8'd0);
		push_entry.fin   = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			chunk_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_count_q <= 8'd0;
			crc_q         <= 16'd0;
		end else if (push) begin
			if (s_axis_tlast) begin
				burst_count_q <= 8'd0;
				crc_q         <= 16'd0;
			end else begin
				burst_count_q <= (cnt_next >= lim) ? 8'd0 : cnt_next[7:0];
				crc_q         <= crc_next;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && s_axis_tlast |=> crc_q == 16'd0 && burst_count_q == 8'd0)
		else $error("crc state not cleared after last word");

	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		push && !cfg_we |=> {1'b0, burst_count_q} < $past(lim))
		else $error("burst count reached limit");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

endmodule

[hdl/cbf_queue.sv]
// ----------------------------------------------------------------------------
// cbf_queue: short queue between front and back of the crc burst framer
// holds classified words so that either side may stall on its own
// ----------------------------------------------------------------------------
module cbf_queue import cbf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty
);

	entry_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q - rd_ptr_q == count_q[QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule

[hdl/cbf_back.sv]
// ----------------------------------------------------------------------------
// cbf_back: output side of the crc burst framer
// drains the queue into the output register and appends the crc trailer
// ----------------------------------------------------------------------------
module cbf_back import cbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      pop_entry,
	input  logic        empty,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam logic [1:0] PH_IMAGE = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;

	logic [1:0] phase_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       start_q;
	logic       crc_q;
	logic       last_q;
	logic       load;

	assign load = !valid_q || m_axis_tready;
	assign pop  = load && (((phase_q == PH_IMAGE) && !empty && !pop_entry.fin) ||
		(phase_q == PH_LOW));

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = {crc_q, start_q};
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IMAGE;
			valid_q <= 1'b0;
		end else if (load) begin
			case (phase_q)
				PH_IMAGE: begin
					valid_q <= !empty;
					if (!empty && pop_entry.fin) begin
						phase_q <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					valid_q <= 1'b1;
					phase_q <= PH_LOW;
				end
				PH_LOW: begin
					valid_q <= 1'b1;
					phase_q <= PH_IMAGE;
				end
				default: begin
					valid_q <= 1'b0;
					phase_q <= PH_IMAGE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (phase_q)
				PH_HIGH: begin
					data_q  <= pop_entry.crc[15:8];
					start_q <= 1'b1;
					crc_q   <= 1'b1;
					last_q  <= 1'b0;
				end
				PH_LOW: begin
					data_q  <= pop_entry.crc[7:0];
					start_q <= 1'b0;
					crc_q   <= 1'b1;
					last_q  <= 1'b1;
				end
				default: begin
					data_q  <= pop_entry.data;
					start_q <= pop_entry.start;
					crc_q   <= 1'b0;
					last_q  <= 1'b0;
				end
			endcase
		end
	end

	a_trailer_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IMAGE |-> !empty)
		else $error("crc trailer without queued word");

	a_high_then_low: assert property (@(posedge clk) disable iff (!arst_n)
		load && phase_q == PH_HIGH |=> phase_q == PH_LOW)
		else $error("crc high byte not followed by low byte");

	a_last_is_crc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> crc_q && !start_q)
		else $error("last word is not a crc low byte");

endmodule

[hdl/firmware_crc_burst_framer.sv]
// ----------------------------------------------------------------------------
// firmware_crc_burst_framer: streams firmware image words with crc-16 trailer
//
// the slave stream carries image words (tdata = data byte, tlast = final word
// of the image). each word is passed to the master stream unchanged with
// tuser[0] set where it opens a write burst of at most chunk_limit words.
// after the final word two crc-16/xmodem words follow as a burst of their
// own: high byte (burst start set) then low byte (tlast set), tuser[1]
// marking both. crc and burst count then clear for the next image. chunk_limit
// is written through cfg_we/cfg_wdata by the user only while the block is idle
// (not enforced by the block); zero acts as one. a slave word is registered in
// the queue, then in the output register. throughput is one word per cycle
// while the queue is not full, set by the combinational byte crc in the front;
// each image adds two crc trailer words in the back. a four-word queue sits
// between them. when the master side stalls the queue fills and s_axis_tready
// drops. reset clears crc, burst count and queue, and sets chunk_limit to 255.
// ----------------------------------------------------------------------------
module firmware_crc_burst_framer import cbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic [1:0]  m_axis_tuser,   // burst_start, is_crc
	output logic        m_axis_tlast
);

	entry_t push_entry;
	entry_t pop_entry;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_empty;

	cbf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	cbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	cbf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_entry     (pop_entry),
		.empty         (q_empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
